// File: rtl/assert_macros.svh
// Assertion helpers for the RTL files; signed_binary_to_bcd.sv includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Property checked on every rising edge once reset is released.
`define ASSERT_PROP(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// Condition that must never hold once reset is released.
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");

`else

`define ASSERT_PROP(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)

`endif

`endif

// File: rtl/sb2b_pkg.sv
package sb2b_pkg;

    localparam int BCD_DIGITS  = 10;
    localparam int NIBBLE_W    = 4;
    localparam int BCD_W       = BCD_DIGITS * NIBBLE_W;
    localparam int DCNT_W      = 4;
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 48;

    localparam logic [NIBBLE_W-1:0] DABBLE_LIMIT = 4'd5;
    localparam logic [NIBBLE_W-1:0] DABBLE_ADJ   = 4'd3;

    typedef logic [BCD_W-1:0] t_bcd;

    // Pre-shift correction of one decimal digit.
    function automatic logic [NIBBLE_W-1:0] dabble_adjust(input logic [NIBBLE_W-1:0] d);
        return (d >= DABBLE_LIMIT) ? d + DABBLE_ADJ : d;
    endfunction

endpackage

// File: rtl/sb2b_dabble_stage.sv
module sb2b_dabble_stage #(
    parameter int INPUT_WIDTH = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_valid,
    input  logic                   i_neg,
    input  sb2b_pkg::t_bcd         i_bcd,
    input  logic [INPUT_WIDTH-1:0] i_bin,
    output logic                   o_valid,
    output logic                   o_neg,
    output sb2b_pkg::t_bcd         o_bcd,
    output logic [INPUT_WIDTH-1:0] o_bin
);
    import sb2b_pkg::*;

    logic                   r_valid;
    logic                   r_neg;
    t_bcd                   r_bcd;
    logic [INPUT_WIDTH-1:0] r_bin;
    t_bcd                   n_bcd;
    t_bcd                   w_adj;

    always_comb begin
        for (int i = 0; i < BCD_DIGITS; i++) begin
            w_adj[i*NIBBLE_W +: NIBBLE_W] = dabble_adjust(i_bcd[i*NIBBLE_W +: NIBBLE_W]);
        end
        // shift the next binary bit into the low digit
        n_bcd = {w_adj[BCD_W-2:0], i_bin[INPUT_WIDTH-1]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_neg <= i_neg;
            r_bcd <= n_bcd;
            r_bin <= {i_bin[INPUT_WIDTH-2:0], 1'b0};
        end
    end

    assign o_valid = r_valid;
    assign o_neg   = r_neg;
    assign o_bcd   = r_bcd;
    assign o_bin   = r_bin;

endmodule

// File: rtl/signed_binary_to_bcd.sv
// Signed binary to packed BCD converter. Each input word carries a two's
// complement integer in its low INPUT_WIDTH bits; each output word carries
// the magnitude as ten BCD digits (least significant digit lowest), the count
// of significant digits (1 for zero) and, on tuser, the negative flag, for
// which a display puts the sign nibble 1101 ahead of the digits. The most
// negative input gives magnitude 2^(INPUT_WIDTH-1). The shift-and-add-3
// conversion runs as a pipeline of one register stage per input bit, after
// a stage that takes the magnitude and before a stage that counts digits,
// and one word can enter every cycle unless an output word waits to be taken.
// The whole pipeline holds while the output word waits.
`include "assert_macros.svh"

module signed_binary_to_bcd #(
    parameter int INPUT_WIDTH = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    input  logic [sb2b_pkg::IN_TDATA_W-1:0]    i_s_axis_tdata,  // value[31:0]
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    output logic [sb2b_pkg::OUT_TDATA_W-1:0]   o_m_axis_tdata,  // digit_count[3:0],
                                                                // bcd_digits[43:4], zero pad
    output logic                               o_m_axis_tuser   // negative
);
    import sb2b_pkg::*;

    logic                   w_en;
    logic [INPUT_WIDTH-1:0] w_raw;
    logic                   w_in_neg;
    logic [INPUT_WIDTH-1:0] w_in_mag;

    logic                   r_s0_valid;
    logic                   r_s0_neg;
    logic [INPUT_WIDTH-1:0] r_s0_mag;

    logic                   w_valid [0:INPUT_WIDTH];
    logic                   w_neg   [0:INPUT_WIDTH];
    t_bcd                   w_bcd   [0:INPUT_WIDTH];
    logic [INPUT_WIDTH-1:0] w_bin   [0:INPUT_WIDTH];

    logic [DCNT_W-1:0]      n_cnt;
    logic                   r_out_valid;
    logic                   r_out_neg;
    logic [DCNT_W-1:0]      r_out_cnt;
    t_bcd                   r_out_bcd;
    logic                   w_out_digits_ok;

    // hold everything while the output word is not taken
    assign w_en            = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = w_en;

    assign w_raw    = i_s_axis_tdata[INPUT_WIDTH-1:0];
    assign w_in_neg = w_raw[INPUT_WIDTH-1];
    assign w_in_mag = w_in_neg ? (~w_raw + {{(INPUT_WIDTH-1){1'b0}}, 1'b1}) : w_raw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
        end else if (w_en) begin
            r_s0_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s0_neg <= w_in_neg;
            r_s0_mag <= w_in_mag;
        end
    end

    assign w_valid[0] = r_s0_valid;
    assign w_neg[0]   = r_s0_neg;
    assign w_bcd[0]   = '0;
    assign w_bin[0]   = r_s0_mag;

    for (genvar k = 0; k < INPUT_WIDTH; k++) begin : g_dabble
        sb2b_dabble_stage #(
            .INPUT_WIDTH (INPUT_WIDTH)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_valid[k]),
            .i_neg   (w_neg[k]),
            .i_bcd   (w_bcd[k]),
            .i_bin   (w_bin[k]),
            .o_valid (w_valid[k+1]),
            .o_neg   (w_neg[k+1]),
            .o_bcd   (w_bcd[k+1]),
            .o_bin   (w_bin[k+1])
        );
    end

    // position of the highest non-zero digit, at least one digit
    always_comb begin
        n_cnt = DCNT_W'(1);
        for (int i = 1; i < BCD_DIGITS; i++) begin
            if (w_bcd[INPUT_WIDTH][i*NIBBLE_W +: NIBBLE_W] != '0) begin
                n_cnt = DCNT_W'(i + 1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_valid[INPUT_WIDTH];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_neg <= w_neg[INPUT_WIDTH];
            r_out_cnt <= n_cnt;
            r_out_bcd <= w_bcd[INPUT_WIDTH];
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out_neg;
    assign o_m_axis_tdata  = {{(OUT_TDATA_W-BCD_W-DCNT_W){1'b0}}, r_out_bcd, r_out_cnt};

    always_comb begin
        w_out_digits_ok = 1'b1;
        for (int i = 0; i < BCD_DIGITS; i++) begin
            if (r_out_bcd[i*NIBBLE_W +: NIBBLE_W] > 4'd9) begin
                w_out_digits_ok = 1'b0;
            end
        end
    end

    `ASSERT_PROP(a_digits_decimal, i_clk, i_rst_n, r_out_valid |-> w_out_digits_ok)
    `ASSERT_PROP(a_count_range, i_clk, i_rst_n, r_out_valid |-> (r_out_cnt >= DCNT_W'(1) && r_out_cnt <= DCNT_W'(BCD_DIGITS)))
    `ASSERT_NEVER(a_zero_not_negative, i_clk, i_rst_n, r_out_valid && r_out_neg && r_out_bcd == '0)
    `ASSERT_PROP(a_stall_holds_pipe, i_clk, i_rst_n, (r_out_valid && !i_m_axis_tready) |=> ($stable(r_s0_valid) && $stable(w_valid[INPUT_WIDTH])))

endmodule
